/* hw/rtl/mftep_pkg.sv */
`default_nettype none
package mftep_pkg;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       first_of_track;
    logic       last_in_track;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  device_byte;
    logic        message_last;
    logic [23:0] new_tempo;
    logic [31:0] event_tick;
    logic [31:0] event_time_us;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
    PH_META_LEN, PH_META_BODY, PH_SYSEX_LEN, PH_SYSEX_BODY
  } phase_e;

  // sequencer around the shared divider / multiplier unit
  typedef enum logic [2:0] {
    SQ_IDLE, SQ_DIV, SQ_MUL_Q, SQ_MUL_R, SQ_DIV2, SQ_EMIT0, SQ_EMIT1
  } seq_e;

  localparam logic [1:0] KIND_DEV   = 2'd0;
  localparam logic [1:0] KIND_TEMPO = 2'd1;
  localparam logic [1:0] KIND_EOT   = 2'd2;
  localparam logic [1:0] KIND_NOSTS = 2'd3;

  localparam logic [7:0]  META_EOT      = 8'h2F;
  localparam logic [7:0]  META_TEMPO    = 8'h51;
  localparam logic [23:0] DEFAULT_TEMPO = 24'd500000;
  localparam logic [14:0] DEFAULT_DIV   = 15'd96;
  localparam logic [7:0]  ST_SYSEX      = 8'hF0;
  localparam logic [7:0]  ST_ESCAPE     = 8'hF7;
  localparam logic [7:0]  ST_META       = 8'hFF;
  localparam logic [3:0]  HI_PROGRAM    = 4'hC;
  localparam logic [3:0]  HI_PRESSURE   = 4'hD;

endpackage
`default_nettype wire

/* hw/rtl/midi_file_track_event_parser_core.sv */
// MIDI file track parser: one track byte per input transaction.
// Input channel in_valid_i/in_stall_o carries track_byte plus first/last
// track markers; output channel out_valid_o/out_stall_i carries 0..2 results
// per byte (device bytes, tempo change, end of track, data without status).
// cfg_we_i/cfg_data_i writes ticks_per_quarter (0 acts as 96); write it idle.
// An ordinary byte is taken and its results are then offered in turn, held
// while the receiver stalls. The byte that ends a delta time runs a shared
// 28-bit restoring divider (one quotient bit per cycle) for d/div and
// d%div, two multiplies by tempo through one shared 32x24 multiplier,
// then a 56/15 restoring division of the remainder product; no new byte
// is taken until that work is done.
// Reset leaves the parser waiting for a delta time, tempo 500000, tick and
// time zero, division 96. Results sit in an output register; while the
// receiver stalls the register holds and no new byte is taken.
`default_nettype none
module midi_file_track_event_parser_core #(
  parameter int unsigned SYSEX_FORWARD_LIMIT = 16384
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire  [14:0]               cfg_data_i,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire  mftep_pkg::in_item_t in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output mftep_pkg::out_item_t      out_data_o
);
  import mftep_pkg::*;

  localparam logic [27:0] SX_LIM = 28'(SYSEX_FORWARD_LIMIT);

  logic [14:0] div_q;
  phase_e      ph_q, ph_d;
  logic [7:0]  run_q, run_d, vst_q, vst_d, meta_q, meta_d;
  logic [27:0] acc_q, acc_d, rem_q, rem_d;
  logic [1:0]  qcnt_q, qcnt_d;
  logic [23:0] tempo_q, tempo_d, gath_q, gath_d;
  logic [31:0] tick_q, tick_d, time_q, time_d;
  logic        fwd_q, fwd_d, fin_q, fin_d;

  // pending results of the current byte
  logic [1:0]  npend_q, npend_d;
  out_item_t   r0_q, r0_d, r1_q, r1_d;

  seq_e        sq_q, sq_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [55:0] dn_q, dn_d;     // dividend shifting out / quotient shifting in
  logic [15:0] pr_q, pr_d;     // partial remainder
  logic [31:0] quo_q, quo_d;   // saved quotient d/div
  logic [55:0] prod_q, prod_d;

  logic [14:0] divisor;
  assign divisor = (div_q == '0) ? DEFAULT_DIV : div_q;

  logic take;
  assign take = in_valid_i && !in_stall_o;
  assign in_stall_o = (sq_q != SQ_IDLE);

  // shared restoring divide step
  logic [15:0] trial;
  logic [16:0] tsub;
  assign trial = {pr_q[14:0], dn_q[55]};
  assign tsub  = {1'b0, trial} - {2'b0, divisor};

  // shared multiplier: operand chosen by sequencer
  logic [31:0] mop;
  logic [55:0] mres;
  assign mop  = (sq_q == SQ_MUL_Q) ? quo_q : {16'b0, pr_q};
  assign mres = mop * {32'b0, tempo_q} ;

  function automatic out_item_t mk(input logic [1:0] k, input logic [7:0] b,
                                   input logic l, input logic [23:0] t,
                                   input logic [31:0] tk, input logic [31:0] tm);
    out_item_t r;
    r.kind = k; r.device_byte = b; r.message_last = l;
    r.new_tempo = t; r.event_tick = tk; r.event_time_us = tm;
    return r;
  endfunction

  // byte parser
  logic        qdone;
  logic [27:0] qacc;
  logic [7:0]  b;
  logic        need_time;
  always_comb begin
    b = in_data_i.track_byte;
    ph_d = ph_q; run_d = run_q; vst_d = vst_q; meta_d = meta_q;
    acc_d = acc_q; rem_d = rem_q; qcnt_d = qcnt_q; tempo_d = tempo_q;
    gath_d = gath_q; tick_d = tick_q; time_d = time_q; fwd_d = fwd_q;
    fin_d = fin_q; npend_d = npend_q; r0_d = r0_q; r1_d = r1_q;
    need_time = 1'b0;
    qacc = '0; qdone = 1'b0;
    if (take) begin
      if (in_data_i.first_of_track) begin
        ph_d = PH_DELTA; run_d = '0; acc_d = '0; qcnt_d = '0; rem_d = '0;
        meta_d = '0; gath_d = '0; tick_d = '0; time_d = '0; vst_d = '0;
        fwd_d = 1'b0; fin_d = 1'b0;
      end
      qacc  = {acc_d[20:0], b[6:0]};
      qdone = !b[7] || (qcnt_d == 2'd3);
      npend_d = '0;
      if (!fin_d) begin
        case (ph_d)
          PH_DELTA: begin
            acc_d = qacc; qcnt_d = qcnt_d + 2'd1;
            if (qdone) begin
              need_time = 1'b1;
              tick_d = tick_d + {4'b0, qacc};
              ph_d = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (b[7]) begin
              if (b == ST_META) ph_d = PH_META_TYPE;
              else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                vst_d = b; ph_d = PH_SYSEX_LEN; acc_d = '0; qcnt_d = '0;
              end else begin
                run_d = b; vst_d = b; ph_d = PH_DATA1;
              end
            end else if (run_d == '0) begin
              r0_d = mk(KIND_NOSTS, b, 1'b1, tempo_d, tick_d, time_d);
              npend_d = 2'd1; ph_d = PH_DELTA; acc_d = '0; qcnt_d = '0;
            end else begin
              vst_d = run_d; ph_d = PH_DATA1;
            end
          end
          PH_DATA2: begin
            r0_d = mk(KIND_DEV, b, 1'b1, tempo_d, tick_d, time_d);
            npend_d = 2'd1; ph_d = PH_DELTA; acc_d = '0; qcnt_d = '0;
          end
          PH_META_TYPE: begin
            meta_d = b; ph_d = PH_META_LEN; acc_d = '0; qcnt_d = '0;
          end
          PH_META_LEN: begin
            acc_d = qacc; qcnt_d = qcnt_d + 2'd1;
            if (qdone) begin
              if (meta_d == META_EOT) begin
                fin_d = 1'b1;
                r0_d = mk(KIND_EOT, 8'h00, 1'b1, tempo_d, tick_d, time_d);
                npend_d = 2'd1;
              end else if (qacc == '0) begin
                ph_d = PH_DELTA; acc_d = '0; qcnt_d = '0;
              end else begin
                if (meta_d == META_TEMPO && qacc != 28'd3) meta_d = '0;
                rem_d = qacc; gath_d = '0; ph_d = PH_META_BODY;
              end
            end
          end
          PH_META_BODY: begin
            if (meta_d == META_TEMPO) gath_d = {gath_d[15:0], b};
            rem_d = rem_d - 28'd1;
            if (rem_d == '0) begin
              if (meta_d == META_TEMPO) begin
                tempo_d = (gath_d == '0) ? DEFAULT_TEMPO : gath_d;
                r0_d = mk(KIND_TEMPO, 8'h00, 1'b1, tempo_d, tick_d, time_d);
                npend_d = 2'd1;
              end
              ph_d = PH_DELTA; acc_d = '0; qcnt_d = '0;
            end
          end
          PH_SYSEX_LEN: begin
            acc_d = qacc; qcnt_d = qcnt_d + 2'd1;
            if (qdone) begin
              if (vst_d == ST_SYSEX) begin
                r0_d = mk(KIND_DEV, ST_SYSEX, 1'b1, tempo_d, tick_d, time_d);
                npend_d = 2'd1;
              end
              fwd_d = (qacc != '0) && (qacc < SX_LIM);
              if (qacc == '0) begin
                ph_d = PH_DELTA; acc_d = '0; qcnt_d = '0;
              end else begin
                rem_d = qacc; ph_d = PH_SYSEX_BODY;
              end
            end
          end
          PH_SYSEX_BODY: begin
            rem_d = rem_d - 28'd1;
            if (fwd_d) begin
              r0_d = mk(KIND_DEV, b, rem_d == '0, tempo_d, tick_d, time_d);
              npend_d = 2'd1;
            end
            if (rem_d == '0) begin
              ph_d = PH_DELTA; acc_d = '0; qcnt_d = '0;
            end
          end
          default: begin
            ph_d = PH_DELTA; acc_d = '0; qcnt_d = '0;
          end
        endcase
        // first data byte of a channel message (direct or running status)
        if ((ph_q == PH_DATA1 && !in_data_i.first_of_track) ||
            (ph_d == PH_DATA1 && ph_q == PH_STATUS && !b[7] && run_d != '0)) begin
          r0_d = mk(KIND_DEV, vst_d, 1'b0, tempo_d, tick_d, time_d);
          if (vst_d[7:4] == HI_PROGRAM || vst_d[7:4] == HI_PRESSURE) begin
            r1_d = mk(KIND_DEV, b, 1'b1, tempo_d, tick_d, time_d);
            ph_d = PH_DELTA; acc_d = '0; qcnt_d = '0;
          end else begin
            r1_d = mk(KIND_DEV, b, 1'b0, tempo_d, tick_d, time_d);
            ph_d = PH_DATA2;
          end
          npend_d = 2'd2;
        end
      end
    end
  end

  // sequencer next state
  always_comb begin
    sq_d = sq_q;
    case (sq_q)
      SQ_IDLE:  if (take) sq_d = need_time ? SQ_DIV :
                           (npend_d != '0 ? SQ_EMIT0 : SQ_IDLE);
      SQ_DIV:   if (cnt_q == 6'd27) sq_d = SQ_MUL_Q;
      SQ_MUL_Q: sq_d = SQ_MUL_R;
      SQ_MUL_R: sq_d = SQ_DIV2;
      SQ_DIV2:  if (cnt_q == 6'd55) sq_d = (npend_q != '0) ? SQ_EMIT0 : SQ_IDLE;
      SQ_EMIT0: if (!out_stall_i) sq_d = (npend_q == 2'd2) ? SQ_EMIT1 : SQ_IDLE;
      SQ_EMIT1: if (!out_stall_i) sq_d = SQ_IDLE;
      default:  sq_d = SQ_IDLE;
    endcase
  end

  // datapath of the shared unit
  always_comb begin
    cnt_d = cnt_q; dn_d = dn_q; pr_d = pr_q; quo_d = quo_q; prod_d = prod_q;
    case (sq_q)
      SQ_IDLE: begin
        cnt_d = '0; pr_d = '0;
        dn_d = {acc_d, 28'b0};
      end
      SQ_DIV, SQ_DIV2: begin
        cnt_d = cnt_q + 6'd1;
        if (!tsub[16]) begin
          pr_d = tsub[15:0]; dn_d = {dn_q[54:0], 1'b1};
        end else begin
          pr_d = trial; dn_d = {dn_q[54:0], 1'b0};
        end
        if (sq_q == SQ_DIV && cnt_q == 6'd27) begin
          quo_d = {4'b0, dn_d[27:0]};
          cnt_d = '0;
        end
      end
      SQ_MUL_Q: prod_d = mres;
      SQ_MUL_R: begin
        dn_d = mres; pr_d = '0;
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_o = (sq_q == SQ_EMIT0) || (sq_q == SQ_EMIT1);
    out_data_o  = (sq_q == SQ_EMIT1) ? r1_q : r0_q;
  end

  // last divide step delivers the final quotient bit in dn_d
  logic [31:0] tsum;
  assign tsum = time_q + prod_q[31:0] + dn_d[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= DEFAULT_DIV; ph_q <= PH_DELTA; run_q <= '0; vst_q <= '0;
      meta_q <= '0; acc_q <= '0; rem_q <= '0; qcnt_q <= '0;
      tempo_q <= DEFAULT_TEMPO; gath_q <= '0; tick_q <= '0; time_q <= '0;
      fwd_q <= 1'b0; fin_q <= 1'b0; npend_q <= '0;
      sq_q <= SQ_IDLE; cnt_q <= '0;
    end else begin
      if (cfg_we_i) div_q <= cfg_data_i;
      sq_q <= sq_d; cnt_q <= cnt_d;
      if (take) begin
        ph_q <= ph_d; run_q <= run_d; vst_q <= vst_d; meta_q <= meta_d;
        acc_q <= acc_d; rem_q <= rem_d; qcnt_q <= qcnt_d; tempo_q <= tempo_d;
        gath_q <= gath_d; tick_q <= tick_d; time_q <= time_d;
        fwd_q <= fwd_d; npend_q <= npend_d;
        fin_q <= fin_d || in_data_i.last_in_track;
      end
      // time add after the remainder division completes; later results are stamped with it
      if (sq_q == SQ_DIV2 && cnt_q == 6'd55) begin
        time_q <= tsum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dn_q <= dn_d; pr_q <= pr_d; quo_q <= quo_d; prod_q <= prod_d;
    if (take) begin
      r0_q <= r0_d; r1_q <= r1_d;
    end
  end

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("took byte while emitting");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed under stall");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_q == SQ_DIV) |-> (cnt_q <= 6'd27)) else $error("divider overran");
  a_emit1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_q == SQ_EMIT1) |-> (npend_q == 2'd2)) else $error("bad second result");
`endif

endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mftep_pkg::*;

  localparam int unsigned SX_LIMIT = 16384;

  // Scoreboard: predicts parser results per accepted byte, checks outputs
  class parser_scoreboard;
    logic [14:0] div_cfg;
    phase_e      phase;
    logic [7:0]  run_sts, voice_sts, meta_kind;
    logic [27:0] qty, remaining;
    logic [1:0]  qty_cnt;
    logic [23:0] tempo, tempo_acc;
    logic [31:0] tick, time_us;
    bit          fwd_sysex, finished;
    out_item_t   pending[$];
    int          errors;

    function void reset_state();
      div_cfg = DEFAULT_DIV;
      tempo = DEFAULT_TEMPO;
      clear_track();
      pending.delete();
      errors = 0;
    endfunction

    function void clear_track();
      phase = PH_DELTA; run_sts = 0; voice_sts = 0; meta_kind = 0;
      qty = 0; qty_cnt = 0; remaining = 0; tempo_acc = 0;
      tick = 0; time_us = 0; fwd_sysex = 0; finished = 0;
    endfunction

    function void push(logic [1:0] k, logic [7:0] b, logic l);
      out_item_t r;
      r.kind = k; r.device_byte = b; r.message_last = l;
      r.new_tempo = tempo; r.event_tick = tick; r.event_time_us = time_us;
      pending.push_back(r);
    endfunction

    function bit take_qty(logic [7:0] b);
      bit done;
      qty = {qty[20:0], b[6:0]};
      done = !b[7] || qty_cnt == 2'd3;
      qty_cnt = qty_cnt + 2'd1;
      return done;
    endfunction

    function void to_delta();
      phase = PH_DELTA; qty = 0; qty_cnt = 0;
    endfunction

    function void advance(logic [27:0] d);
      longint unsigned dv, q, r, add;
      dv = (div_cfg == 0) ? 96 : div_cfg;
      q = d / dv; r = d % dv;
      add = q * tempo + (r * tempo) / dv;
      tick = tick + d;
      time_us = time_us + add[31:0];
    endfunction

    function void data1(logic [7:0] b);
      push(KIND_DEV, voice_sts, 0);
      if (voice_sts[7:4] == HI_PROGRAM || voice_sts[7:4] == HI_PRESSURE) begin
        push(KIND_DEV, b, 1);
        to_delta();
      end else begin
        push(KIND_DEV, b, 0);
        phase = PH_DATA2;
      end
    endfunction

    // note one accepted input transaction
    function void note_input(in_item_t it);
      logic [7:0] b;
      b = it.track_byte;
      if (it.first_of_track) clear_track();
      if (finished) return;
      case (phase)
        PH_DELTA: if (take_qty(b)) begin
          advance(qty);
          phase = PH_STATUS;
        end
        PH_STATUS: begin
          if (b[7]) begin
            if (b == ST_META) phase = PH_META_TYPE;
            else if (b == ST_SYSEX || b == ST_ESCAPE) begin
              voice_sts = b; phase = PH_SYSEX_LEN; qty = 0; qty_cnt = 0;
            end else begin
              run_sts = b; voice_sts = b; phase = PH_DATA1;
            end
          end else if (run_sts == 0) begin
            push(KIND_NOSTS, b, 1);
            to_delta();
          end else begin
            voice_sts = run_sts;
            data1(b);
          end
        end
        PH_DATA1: data1(b);
        PH_DATA2: begin
          push(KIND_DEV, b, 1);
          to_delta();
        end
        PH_META_TYPE: begin
          meta_kind = b; phase = PH_META_LEN; qty = 0; qty_cnt = 0;
        end
        PH_META_LEN: if (take_qty(b)) begin
          if (meta_kind == META_EOT) begin
            finished = 1;
            push(KIND_EOT, 0, 1);
          end else if (qty == 0) to_delta();
          else begin
            if (meta_kind == META_TEMPO && qty != 3) meta_kind = 0;
            remaining = qty; tempo_acc = 0; phase = PH_META_BODY;
          end
        end
        PH_META_BODY: begin
          if (meta_kind == META_TEMPO) tempo_acc = {tempo_acc[15:0], b};
          remaining = remaining - 1;
          if (remaining == 0) begin
            if (meta_kind == META_TEMPO) begin
              tempo = (tempo_acc != 0) ? tempo_acc : DEFAULT_TEMPO;
              push(KIND_TEMPO, 0, 1);
            end
            to_delta();
          end
        end
        PH_SYSEX_LEN: if (take_qty(b)) begin
          if (voice_sts == ST_SYSEX) push(KIND_DEV, ST_SYSEX, 1);
          fwd_sysex = qty > 0 && qty < 28'(SX_LIMIT);
          if (qty == 0) to_delta();
          else begin
            remaining = qty; phase = PH_SYSEX_BODY;
          end
        end
        PH_SYSEX_BODY: begin
          remaining = remaining - 1;
          if (fwd_sysex) push(KIND_DEV, b, remaining == 0);
          if (remaining == 0) to_delta();
        end
        default: to_delta();
      endcase
      if (it.last_in_track) finished = 1;
    endfunction

    // check one accepted output transaction
    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch expected kind=%0d byte=%h last=%0d tempo=%0d tick=%0d us=%0d",
                 $realtime, exp_r.kind, exp_r.device_byte, exp_r.message_last,
                 exp_r.new_tempo, exp_r.event_tick, exp_r.event_time_us);
        $display("%0t:          actual   kind=%0d byte=%h last=%0d tempo=%0d tick=%0d us=%0d",
                 $realtime, got.kind, got.device_byte, got.message_last,
                 got.new_tempo, got.event_tick, got.event_time_us);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [14:0] cfg_data_i = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  out_item_t   out_data_o;

  parser_scoreboard sb;
  in_item_t byte_q[$];
  bit  calm = 0;
  bit  drv_done = 0;
  int  idle_cycles = 0;
  int  results_seen = 0;

  always #4 clk_i = ~clk_i;

  midi_file_track_event_parser_core #(
    .SYSEX_FORWARD_LIMIT(SX_LIMIT)
  ) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        results_seen++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall_i <= 1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 0;
    end
  end

  task automatic add_byte(logic [7:0] b, bit first = 0, bit last = 0);
    in_item_t it;
    it.track_byte = b; it.first_of_track = first; it.last_in_track = last;
    byte_q.push_back(it);
  endtask

  task automatic add_vlq(logic [27:0] v);
    if (v >= 28'h200000) add_byte({1'b1, v[27:21]});
    if (v >= 28'h4000) add_byte({1'b1, v[20:14]});
    if (v >= 28'h80) add_byte({1'b1, v[13:7]});
    add_byte({1'b0, v[6:0]});
  endtask

  function automatic logic [27:0] rand_delta();
    case ($urandom_range(0, 5))
      0: return 28'd0;
      1: return 28'($urandom_range(0, 127));
      2: return 28'($urandom_range(0, 16383));
      3: return 28'($urandom);
      default: return 28'($urandom_range(0, 400));
    endcase
  endfunction

  // one random event appended to the byte list
  task automatic add_event();
    int sel, len;
    logic [7:0] st;
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
      return;
    end
    add_vlq(rand_delta());
    if (sel < 45) begin
      st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      if ($urandom_range(0, 2) != 0) add_byte(st);
      add_byte(8'($urandom_range(0, 127)));
      add_byte(8'($urandom_range(0, 127)));
    end else if (sel < 55) begin
      add_byte(8'($urandom_range(0, 127)));
    end else if (sel < 65) begin
      add_byte(ST_META); add_byte(META_TEMPO);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : 3;
      add_vlq(28'(len));
      repeat (len) add_byte(8'($urandom));
    end else if (sel < 75) begin
      add_byte(ST_META); add_byte(8'($urandom));
      len = $urandom_range(0, 5);
      add_vlq(28'(len));
      repeat (len) add_byte(8'($urandom));
    end else if (sel < 92) begin
      add_byte(($urandom_range(0, 1) == 1) ? ST_SYSEX : ST_ESCAPE);
      len = $urandom_range(0, 6);
      add_vlq(28'(len));
      repeat (len) add_byte(8'($urandom));
    end else begin
      add_byte(8'($urandom_range(241, 254)));
      add_byte(8'($urandom)); add_byte(8'($urandom));
    end
  endtask

  task automatic write_div(logic [14:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_data_i <= v;
    sb.div_cfg = v;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // drive queued bytes with random sender gaps
  task automatic send_bytes();
    in_item_t it;
    while (byte_q.size() > 0) begin
      if (!calm && $urandom_range(0, 6) == 0) begin
        in_valid_i <= 0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      it = byte_q.pop_front();
      in_valid_i <= 1; in_data_i <= it;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() > 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  initial begin
    int total, i;
    logic [14:0] divs[6];
    sb = new();
    sb.reset_state();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    repeat (2) @(negedge clk_i);

    // directed: reset division, edge fields
    add_byte(8'h00, 1);
    add_byte(8'h45);                    // data without status
    add_byte(8'h81); add_byte(8'h80); add_byte(8'h80); add_byte(8'hFF);  // long quantity
    add_byte(8'h90); add_byte(8'h7F); add_byte(8'h00);
    add_byte(8'h00); add_byte(8'h40); add_byte(8'h01);   // running status
    add_byte(8'h00); add_byte(8'hC5); add_byte(8'h7F);   // program
    add_byte(8'h00); add_byte(8'hF3); add_byte(8'h12); add_byte(8'h34);
    add_byte(8'h00); add_byte(ST_META); add_byte(META_TEMPO); add_byte(8'h03);
    add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);   // zero tempo
    add_byte(8'h10); add_byte(ST_META); add_byte(META_TEMPO); add_byte(8'h02);
    add_byte(8'hFF); add_byte(8'hFF);                    // odd tempo length
    add_byte(8'h00); add_byte(ST_META); add_byte(META_TEMPO); add_byte(8'h03);
    add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
    add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h7F);
    add_byte(ST_SYSEX); add_byte(8'h02); add_byte(8'h11); add_byte(8'hF7);
    add_byte(8'h00); add_byte(ST_ESCAPE); add_byte(8'h00);
    add_byte(8'h00); add_byte(ST_SYSEX); add_byte(8'h81); add_byte(8'h80);
    add_byte(8'h00);                                     // sysex at limit, not forwarded
    add_byte(8'h00); add_byte(ST_META); add_byte(META_EOT); add_byte(8'h00);
    add_byte(8'h90);                                     // finished track ignores
    add_byte(8'h00, 1); add_byte(8'h90); add_byte(8'h40, 0, 1);  // cut short
    add_byte(8'h55);
    send_bytes();
    drain();

    // random phases across division settings
    divs = '{15'd0, 15'd1, 15'd32767, 15'd480, 15'd7, 15'd96};
    total = 0;
    for (i = 0; i < 6; i++) begin
      write_div(i == 5 ? divs[i] : (i >= 3 ? 15'($urandom_range(1, 32767)) : divs[i]));
      if (i == 5) calm = 1;
      add_byte(8'h00, 1);
      add_event();
      while (byte_q.size() < 310) begin
        if ($urandom_range(0, 60) == 0) add_byte(8'($urandom), 1);
        add_event();
      end
      if ($urandom_range(0, 1) == 1) begin
        add_byte(8'h00); add_byte(ST_META); add_byte(META_EOT); add_byte(8'h00);
      end
      total += byte_q.size();
      send_bytes();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
